// ===== rtl/eaae_pkg.sv =====
`default_nettype none

package eaae_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;
    localparam int unsigned START_BITS        = 17;
    localparam int unsigned LEN_BITS          = 11;
    localparam int unsigned CFG_INDEX_BITS    = 3;
    localparam int unsigned CFG_DATA_BITS     = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_RES       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_MAC       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_ECDHE     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_HYBRID    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_KEM_CTEXT = 3'd4;

    localparam logic [7:0] CODE_RES_RST       = 8'd3;
    localparam logic [7:0] CODE_MAC_RST       = 8'd11;
    localparam logic [7:0] CODE_ECDHE_RST     = 8'd150;
    localparam logic [7:0] CODE_HYBRID_RST    = 8'd151;
    localparam logic [7:0] CODE_KEM_CTEXT_RST = 8'd152;

    localparam logic [START_BITS-1:0] FIRST_ATTR_START = 17'd8;

    // Fixed attribute spans and value sizes
    localparam logic [LEN_BITS-1:0] HYBRID_TOTAL    = 11'd1124;
    localparam logic [LEN_BITS-1:0] KEM_CTEXT_TOTAL = 11'd1092;
    localparam logic [LEN_BITS-1:0] HYBRID_SIZE     = 11'd1120;
    localparam logic [LEN_BITS-1:0] KEM_CTEXT_SIZE  = 11'd1088;
    localparam logic [LEN_BITS-1:0] ECDHE_SIZE      = 11'd32;
    localparam logic [LEN_BITS-1:0] MAC_SIZE        = 11'd16;
    localparam logic [LEN_BITS-1:0] ATTR_HEAD_LEN   = 11'd4;

    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_BITS_HI = 3'd2,
        PH_BITS_LO = 3'd3,
        PH_PAD1    = 3'd4,
        PH_PAD2    = 3'd5,
        PH_VALUE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        OC_FOUND     = 2'd0,
        OC_NOT_FOUND = 2'd1,
        OC_REJECTED  = 2'd2,
        OC_TRUNCATED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [7:0] code_res;
        logic [7:0] code_mac;
        logic [7:0] code_ecdhe;
        logic [7:0] code_hybrid;
        logic [7:0] code_kem_ctext;
    } cfg_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
        logic [7:0] wanted_type;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       done_res;
        outcome_t   outcome;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/eaae_if.sv =====
`default_nettype none

interface eaae_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic [7:0] wanted_type;

    modport source (output valid, output packet_byte, output last_byte, output wanted_type,
                    input ready);
    modport sink (input valid, input packet_byte, input last_byte, input wanted_type,
                  output ready);
endinterface

interface eaae_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] outcome;

    modport source (output valid, output value_byte, output byte_valid, output done_res,
                    output outcome, input ready);
    modport sink (input valid, input value_byte, input byte_valid, input done_res,
                  input outcome, output ready);
endinterface

`default_nettype wire

// ===== rtl/eaae_cfg_regs.sv =====
`default_nettype none

module eaae_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [eaae_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [eaae_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output eaae_pkg::cfg_t                          cfg
);
    import eaae_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CODE_RES:       cfg_next.code_res       = cfg_data;
                REG_CODE_MAC:       cfg_next.code_mac       = cfg_data;
                REG_CODE_ECDHE:     cfg_next.code_ecdhe     = cfg_data;
                REG_CODE_HYBRID:    cfg_next.code_hybrid    = cfg_data;
                REG_CODE_KEM_CTEXT: cfg_next.code_kem_ctext = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_res       <= CODE_RES_RST;
            cfg_reg.code_mac       <= CODE_MAC_RST;
            cfg_reg.code_ecdhe     <= CODE_ECDHE_RST;
            cfg_reg.code_hybrid    <= CODE_HYBRID_RST;
            cfg_reg.code_kem_ctext <= CODE_KEM_CTEXT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/eaae_walker.sv =====
`default_nettype none

module eaae_walker #(
    parameter int unsigned POSITION_BITS = eaae_pkg::POSITION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire eaae_pkg::in_item_t item,
    input  wire eaae_pkg::cfg_t     cfg,
    output logic                    res_valid,
    output eaae_pkg::res_t          res
);
    import eaae_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [START_BITS-1:0]    start_reg, start_next;
    phase_t                   phase_reg, phase_next;
    logic [7:0]               cur_type_reg, cur_type_next;
    logic [7:0]               target_reg, target_next;
    logic [LEN_BITS-1:0]      attr_len_reg, attr_len_next;
    logic [7:0]               bits_hi_reg, bits_hi_next;
    logic [LEN_BITS-1:0]      remain_reg, remain_next;
    logic                     reported_reg, reported_next;

    logic [7:0]          b;
    logic                last;
    logic                at_start;
    logic [LEN_BITS-1:0] total;
    logic [LEN_BITS-1:0] size;
    logic [15:0]         bit_count;
    logic [12:0]         vlen;
    logic [LEN_BITS-1:0] remain_dec;

    assign b          = item.packet_byte;
    assign last       = item.last_byte;
    assign at_start   = ({{(START_BITS-POSITION_BITS){1'b0}}, pos_reg} == start_reg);
    assign bit_count  = {bits_hi_reg, b};
    assign vlen       = bit_count[15:3];
    assign remain_dec = remain_reg - 11'd1;

    always_comb
    begin
        if (cur_type_reg == cfg.code_hybrid)
            total = HYBRID_TOTAL;
        else if (cur_type_reg == cfg.code_kem_ctext)
            total = KEM_CTEXT_TOTAL;
        else
            total = {1'b0, b, 2'b00};

        if (cur_type_reg == cfg.code_mac)
            size = MAC_SIZE;
        else if (cur_type_reg == cfg.code_ecdhe)
            size = ECDHE_SIZE;
        else if (cur_type_reg == cfg.code_hybrid)
            size = HYBRID_SIZE;
        else if (cur_type_reg == cfg.code_kem_ctext)
            size = KEM_CTEXT_SIZE;
        else
            size = '0;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        start_next    = start_reg;
        phase_next    = phase_reg;
        cur_type_next = cur_type_reg;
        target_next   = (pos_reg == '0) ? item.wanted_type : target_reg;
        attr_len_next = attr_len_reg;
        bits_hi_next  = bits_hi_reg;
        remain_next   = remain_reg;
        reported_next = reported_reg;

        res_valid      = 1'b0;
        res.value_byte = '0;
        res.byte_valid = 1'b0;
        res.done_res   = 1'b0;
        res.outcome    = OC_FOUND;

        if (!reported_reg)
        begin
            case (phase_reg)
                PH_SEEK:
                begin
                    if (at_start)
                    begin
                        cur_type_next = b;
                        if (last)
                        begin
                            res_valid   = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome = OC_NOT_FOUND;
                        end
                        else
                            phase_next = PH_LENGTH;
                    end
                    else if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_NOT_FOUND;
                    end
                end
                PH_LENGTH:
                begin
                    attr_len_next = total;
                    if (cur_type_reg == target_next)
                    begin
                        if (cur_type_reg == cfg.code_res)
                        begin
                            if (total < ATTR_HEAD_LEN)
                            begin
                                res_valid    = 1'b1;
                                res.done_res = 1'b1;
                                res.outcome  = OC_REJECTED;
                            end
                            else if (last)
                            begin
                                res_valid    = 1'b1;
                                res.done_res = 1'b1;
                                res.outcome  = OC_TRUNCATED;
                            end
                            else
                                phase_next = PH_BITS_HI;
                        end
                        else if (size == '0)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome  = OC_REJECTED;
                        end
                        else if (last)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome  = OC_TRUNCATED;
                        end
                        else
                        begin
                            remain_next = size;
                            phase_next  = PH_PAD1;
                        end
                    end
                    // a zero-sized attribute would never advance the walk
                    else if (total == '0)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_REJECTED;
                    end
                    else if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_NOT_FOUND;
                    end
                    else
                    begin
                        start_next = start_reg + {{(START_BITS-LEN_BITS){1'b0}}, total};
                        phase_next = PH_SEEK;
                    end
                end
                PH_BITS_HI:
                begin
                    bits_hi_next = b;
                    if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_TRUNCATED;
                    end
                    else
                        phase_next = PH_BITS_LO;
                end
                PH_BITS_LO:
                begin
                    if (attr_len_reg < ATTR_HEAD_LEN ||
                        vlen > {2'b00, attr_len_reg - ATTR_HEAD_LEN})
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_REJECTED;
                    end
                    else if (vlen == '0)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_FOUND;
                    end
                    else if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_TRUNCATED;
                    end
                    else
                    begin
                        remain_next = vlen[LEN_BITS-1:0];
                        phase_next  = PH_VALUE;
                    end
                end
                PH_PAD1, PH_PAD2:
                begin
                    if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_TRUNCATED;
                    end
                    else
                        phase_next = (phase_reg == PH_PAD1) ? PH_PAD2 : PH_VALUE;
                end
                PH_VALUE:
                begin
                    remain_next    = remain_dec;
                    res_valid      = 1'b1;
                    res.value_byte = b;
                    res.byte_valid = 1'b1;
                    if (remain_dec == '0)
                    begin
                        res.done_res = 1'b1;
                        res.outcome  = OC_FOUND;
                    end
                    else if (last)
                    begin
                        res.done_res = 1'b1;
                        res.outcome  = OC_TRUNCATED;
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK;
                    if (last)
                    begin
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OC_NOT_FOUND;
                    end
                end
            endcase
        end

        if (res.done_res)
            reported_next = 1'b1;

        // saturate so that far attributes are simply never reached
        if (pos_reg != POS_MAX)
            pos_next = pos_reg + 1'b1;

        if (last)
        begin
            pos_next      = '0;
            start_next    = FIRST_ATTR_START;
            phase_next    = PH_SEEK;
            cur_type_next = '0;
            attr_len_next = '0;
            bits_hi_next  = '0;
            remain_next   = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_reg    <= FIRST_ATTR_START;
            phase_reg    <= PH_SEEK;
            cur_type_reg <= '0;
            target_reg   <= '0;
            attr_len_reg <= '0;
            bits_hi_reg  <= '0;
            remain_reg   <= '0;
            reported_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            phase_reg    <= phase_next;
            cur_type_reg <= cur_type_next;
            target_reg   <= target_next;
            attr_len_reg <= attr_len_next;
            bits_hi_reg  <= bits_hi_next;
            remain_reg   <= remain_next;
            reported_reg <= reported_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/eap_aka_attribute_extractor.sv =====
// Path: a transaction that is accepted is held in the input register, and its result
// (if any) is then loaded into the result register by the walk step.
// Throughput: one message byte per cycle; set by the walk step between the input register
// and the result register, stalled only while a full result register is not taken.
// Reset: rst_n clears the walk state, empties both registers and loads the type code
// registers with their default codes.
`default_nettype none

module eap_aka_attribute_extractor #(
    parameter int unsigned POSITION_BITS = eaae_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    eaae_msg_if.sink                                 msg,
    eaae_res_if.source                               result,
    input  wire logic                                cfg_we,
    input  wire logic [eaae_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [eaae_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import eaae_pkg::*;

    cfg_t     cfg;
    in_item_t in_item_reg;
    logic     in_valid_reg;
    res_t     out_reg;
    logic     out_valid_reg, out_valid_next;
    logic     slot_free;
    logic     step;
    logic     res_valid;
    res_t     res;

    eaae_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eaae_walker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign slot_free = !out_valid_reg || result.ready;
    assign step      = in_valid_reg && slot_free;
    assign msg.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (msg.ready)
            in_valid_reg <= msg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            in_item_reg.packet_byte <= msg.packet_byte;
            in_item_reg.last_byte   <= msg.last_byte;
            in_item_reg.wanted_type <= msg.wanted_type;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = res_valid;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load the payload only with a new transaction, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    assign result.valid      = out_valid_reg;
    assign result.value_byte = out_reg.value_byte;
    assign result.byte_valid = out_reg.byte_valid;
    assign result.done_res   = out_reg.done_res;
    assign result.outcome    = out_reg.outcome;

endmodule

`default_nettype wire

// ===== rtl/eaae_checker.sv =====
`default_nettype none

module eaae_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] value_byte,
    input wire logic       byte_valid,
    input wire logic       done_res,
    input wire logic [1:0] outcome
);
    import eaae_pkg::*;

    // an outcome other than found is only reported with the closing transaction
    a_outcome_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> outcome == OC_FOUND)
        else $error("outcome set on a transaction that does not close the message");

    // a result without a value byte always closes the message
    a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !byte_valid |-> done_res)
        else $error("result with no value byte does not close the message");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !byte_valid |-> value_byte == 8'd0)
        else $error("value byte not zero when no value byte is carried");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(value_byte) &&
            $stable(byte_valid) && $stable(done_res) && $stable(outcome))
        else $error("stalled result transaction changed");

endmodule

bind eap_aka_attribute_extractor eaae_checker u_eaae_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .value_byte (result.value_byte),
    .byte_valid (result.byte_valid),
    .done_res   (result.done_res),
    .outcome    (result.outcome)
);

`default_nettype wire
